// File: hdl/bdmr_pkg.sv
// ----------------------------------------------------------------------------
// bdmr_pkg
// Types, codes and constants shared by the dispatch mode relay controller.
// ----------------------------------------------------------------------------
package bdmr_pkg;

  typedef enum logic [2:0] {
    MODE_DEFAULT = 3'd0,
    MODE_PEAK    = 3'd1,
    MODE_CHARGE  = 3'd2,
    MODE_CURTAIL = 3'd3,
    MODE_PROTECT = 3'd4,
    MODE_FORCED  = 3'd5
  } mode_e;

  typedef enum logic [2:0] {
    REG_PEAK_START   = 3'd0,
    REG_PEAK_END     = 3'd1,
    REG_CHARGE_START = 3'd2,
    REG_CHARGE_END   = 3'd3,
    REG_SOC_MIN      = 3'd4,
    REG_SOC_MIN_BAND = 3'd5,
    REG_SOC_MAX      = 3'd6,
    REG_SOC_MAX_BAND = 3'd7
  } reg_idx_e;

  localparam int unsigned CfgDataW = 10;

  // epoch / 3600 == (epoch >> 4) / 225; reciprocal is exact for 28-bit operands
  localparam logic [28:0] Div225Recip = 29'd305419897;
  localparam int unsigned Div225Shift = 36;
  // hours / 24 == (hours >> 3) / 3; reciprocal is exact for 18-bit operands
  localparam logic [18:0] Div3Recip   = 19'd349526;
  localparam int unsigned Div3Shift   = 20;
  localparam logic [4:0]  HoursPerDay = 5'd24;

  localparam logic [9:0] SocMinRst     = 10'd200;
  localparam logic [9:0] SocMinBandRst = 10'd50;
  localparam logic [9:0] SocMaxRst     = 10'd950;
  localparam logic [9:0] SocMaxBandRst = 10'd30;

  typedef struct packed {
    logic        req_type;
    logic [31:0] epoch_sec;
    logic        bms_ok;
    logic [9:0]  soc_tenths;
    logic [2:0]  cmd_mode;
    logic [31:0] cmd_expiry;
  } req_t;

  typedef struct packed {
    logic [2:0] mode;
    logic       export_on;
    logic       discharge_on;
    logic       charge_on;
    logic       curtail_lamp;
  } res_t;

  typedef struct packed {
    logic [4:0] peak_start_hour;
    logic [4:0] peak_end_hour;
    logic [4:0] charge_start_hour;
    logic [4:0] charge_end_hour;
    logic [9:0] soc_min;
    logic [9:0] soc_min_band;
    logic [9:0] soc_max;
    logic [9:0] soc_max_band;
  } cfg_t;

  // start == end disables; start > end wraps past midnight
  function automatic logic in_window(logic [4:0] hour, logic [4:0] start_h,
                                     logic [4:0] end_h);
    logic hit;
    if (start_h == end_h) begin
      hit = 1'b0;
    end else if (start_h < end_h) begin
      hit = (hour >= start_h) && (hour < end_h);
    end else begin
      hit = (hour >= start_h) || (hour < end_h);
    end
    return hit;
  endfunction

endpackage

// File: hdl/bdmr_req_if.sv
// ----------------------------------------------------------------------------
// bdmr_req_if
// Valid/ready channel carrying request items into the controller.
// ----------------------------------------------------------------------------
interface bdmr_req_if;
  logic            valid;
  logic            ready;
  bdmr_pkg::req_t  payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// File: hdl/bdmr_res_if.sv
// ----------------------------------------------------------------------------
// bdmr_res_if
// Valid/ready channel carrying mode and relay results out of the controller.
// ----------------------------------------------------------------------------
interface bdmr_res_if;
  logic            valid;
  logic            ready;
  bdmr_pkg::res_t  payload;

  modport source (output valid, output payload, input ready);
  modport sink   (input valid, input payload, output ready);
endinterface

// File: hdl/battery_dispatch_mode_relay_controller_core.sv
// Throughput: one item per cycle unless a stalled result sink holds the whole pipe,
// set by the in-order pipeline (input register, two reciprocal-multiply stages,
// hour stage, dispatch/result stage).
// Commands take the same path and update the held command with no result.
// Reset clears pipeline valids, held command and latches; registers take defaults.
// ----------------------------------------------------------------------------
// battery_dispatch_mode_relay_controller_core
// Battery dispatch mode selection and relay drive, fed by poll and command items.
// ----------------------------------------------------------------------------
module battery_dispatch_mode_relay_controller_core (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  bdmr_req_if.sink                       req,
  bdmr_res_if.source                     res,
  input  logic                           cfg_we_i,
  input  logic [2:0]                     cfg_idx_i,
  input  logic [bdmr_pkg::CfgDataW-1:0]  cfg_wdata_i
);

  bdmr_pkg::cfg_t  cfg;
  bdmr_pkg::req_t  pipe_item;
  logic            pipe_valid;
  logic [4:0]      pipe_hour;
  logic            res_valid;
  logic            adv;

  // whole pipe moves unless a finished result is waiting on a stalled sink
  assign adv       = !res_valid || res.ready;
  assign req.ready = adv;
  assign res.valid = res_valid;

  bdmr_cfg_regs u_cfg (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_idx_i   (cfg_idx_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cfg_o       (cfg)
  );

  bdmr_hour_pipe u_hour (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .adv_i   (adv),
    .valid_i (req.valid),
    .item_i  (req.payload),
    .valid_o (pipe_valid),
    .item_o  (pipe_item),
    .hour_o  (pipe_hour)
  );

  bdmr_dispatch u_dispatch (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .adv_i       (adv),
    .valid_i     (pipe_valid),
    .item_i      (pipe_item),
    .hour_i      (pipe_hour),
    .cfg_i       (cfg),
    .res_valid_o (res_valid),
    .res_o       (res.payload)
  );

endmodule

// File: hdl/bdmr_cfg_regs.sv
// ----------------------------------------------------------------------------
// bdmr_cfg_regs
// Schedule and SOC limit registers behind the plain write port.
// ----------------------------------------------------------------------------
module bdmr_cfg_regs (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [2:0]                     cfg_idx_i,
  input  logic [bdmr_pkg::CfgDataW-1:0]  cfg_wdata_i,
  output bdmr_pkg::cfg_t                 cfg_o
);

  bdmr_pkg::cfg_t cfg_q, cfg_d;

  always_comb begin
    cfg_d = cfg_q;
    if (cfg_we_i) begin
      unique case (bdmr_pkg::reg_idx_e'(cfg_idx_i))
        bdmr_pkg::REG_PEAK_START:   cfg_d.peak_start_hour   = cfg_wdata_i[4:0];
        bdmr_pkg::REG_PEAK_END:     cfg_d.peak_end_hour     = cfg_wdata_i[4:0];
        bdmr_pkg::REG_CHARGE_START: cfg_d.charge_start_hour = cfg_wdata_i[4:0];
        bdmr_pkg::REG_CHARGE_END:   cfg_d.charge_end_hour   = cfg_wdata_i[4:0];
        bdmr_pkg::REG_SOC_MIN:      cfg_d.soc_min           = cfg_wdata_i;
        bdmr_pkg::REG_SOC_MIN_BAND: cfg_d.soc_min_band      = cfg_wdata_i;
        bdmr_pkg::REG_SOC_MAX:      cfg_d.soc_max           = cfg_wdata_i;
        bdmr_pkg::REG_SOC_MAX_BAND: cfg_d.soc_max_band      = cfg_wdata_i;
        default:                    cfg_d = cfg_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.peak_start_hour   <= '0;
      cfg_q.peak_end_hour     <= '0;
      cfg_q.charge_start_hour <= '0;
      cfg_q.charge_end_hour   <= '0;
      cfg_q.soc_min           <= bdmr_pkg::SocMinRst;
      cfg_q.soc_min_band      <= bdmr_pkg::SocMinBandRst;
      cfg_q.soc_max           <= bdmr_pkg::SocMaxRst;
      cfg_q.soc_max_band      <= bdmr_pkg::SocMaxBandRst;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  assign cfg_o = cfg_q;

endmodule

// File: hdl/bdmr_hour_pipe.sv
// ----------------------------------------------------------------------------
// bdmr_hour_pipe
// Input register plus three stages extracting the UTC hour of day from the
// epoch by reciprocal multiplication; the item rides along unchanged.
// ----------------------------------------------------------------------------
module bdmr_hour_pipe (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            adv_i,
  input  logic            valid_i,
  input  bdmr_pkg::req_t  item_i,
  output logic            valid_o,
  output bdmr_pkg::req_t  item_o,
  output logic [4:0]      hour_o
);

  logic            s1_valid_q, s2_valid_q, s3_valid_q, s4_valid_q;
  bdmr_pkg::req_t  s1_item_q, s2_item_q, s3_item_q, s4_item_q;

  logic [56:0] prod1;
  logic [20:0] hours_d, s2_hours_q, s3_hours_q;
  logic [37:0] prod2;
  logic [17:0] days_d, s3_days_q;
  logic [4:0]  hour_d, s4_hour_q;

  // total hours since epoch = floor(epoch / 3600)
  assign prod1   = 57'(s1_item_q.epoch_sec[31:4]) * 57'(bdmr_pkg::Div225Recip);
  assign hours_d = prod1[56:bdmr_pkg::Div225Shift];

  // whole days = floor(hours / 24)
  assign prod2  = 38'(s2_hours_q[20:3]) * 38'(bdmr_pkg::Div3Recip);
  assign days_d = prod2[37:bdmr_pkg::Div3Shift];

  assign hour_d = 5'(s3_hours_q - 21'(s3_days_q) * 21'(bdmr_pkg::HoursPerDay));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s1_valid_q <= 1'b0;
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
      s4_valid_q <= 1'b0;
    end else if (adv_i) begin
      s1_valid_q <= valid_i;
      s2_valid_q <= s1_valid_q;
      s3_valid_q <= s2_valid_q;
      s4_valid_q <= s3_valid_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      s1_item_q  <= item_i;
      s2_item_q  <= s1_item_q;
      s2_hours_q <= hours_d;
      s3_item_q  <= s2_item_q;
      s3_hours_q <= s2_hours_q;
      s3_days_q  <= days_d;
      s4_item_q  <= s3_item_q;
      s4_hour_q  <= hour_d;
    end
  end

  assign valid_o = s4_valid_q;
  assign item_o  = s4_item_q;
  assign hour_o  = s4_hour_q;

endmodule

// File: hdl/bdmr_dispatch.sv
// ----------------------------------------------------------------------------
// bdmr_dispatch
// Held command, protect and inhibit latches, mode priority and relay
// decode, with the result register.
// ----------------------------------------------------------------------------
module bdmr_dispatch (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            adv_i,
  input  logic            valid_i,
  input  bdmr_pkg::req_t  item_i,
  input  logic [4:0]      hour_i,
  input  bdmr_pkg::cfg_t  cfg_i,
  output logic            res_valid_o,
  output bdmr_pkg::res_t  res_o
);

  logic [2:0]     held_mode_q, held_mode_d;
  logic [31:0]    held_expiry_q, held_expiry_d;
  logic           protect_q, protect_d;
  logic           inhibit_q, inhibit_d;
  logic           res_valid_q;
  bdmr_pkg::res_t res_q, res_d;

  logic        expire, time_known, low;
  logic [2:0]  cur_mode, cand, mode;
  logic [10:0] min_release, max_sum;

  assign time_known  = (item_i.epoch_sec != '0);
  assign expire      = (held_expiry_q != '0) && (item_i.epoch_sec >= held_expiry_q);
  assign cur_mode    = expire ? 3'(bdmr_pkg::MODE_DEFAULT) : held_mode_q;
  assign low         = item_i.soc_tenths < cfg_i.soc_min;
  assign min_release = 11'(cfg_i.soc_min) + 11'(cfg_i.soc_min_band);
  // soc <= max - band, kept unsigned as soc + band <= max
  assign max_sum     = 11'(item_i.soc_tenths) + 11'(cfg_i.soc_max_band);

  always_comb begin
    held_mode_d   = held_mode_q;
    held_expiry_d = held_expiry_q;
    protect_d     = protect_q;
    inhibit_d     = inhibit_q;
    cand          = bdmr_pkg::MODE_DEFAULT;
    mode          = bdmr_pkg::MODE_DEFAULT;
    res_d         = '0;

    if (item_i.req_type) begin
      held_mode_d   = (item_i.cmd_mode > 3'(bdmr_pkg::MODE_FORCED)) ?
                      3'(bdmr_pkg::MODE_DEFAULT) : item_i.cmd_mode;
      held_expiry_d = item_i.cmd_expiry;
    end else begin
      if (expire) begin
        held_mode_d   = bdmr_pkg::MODE_DEFAULT;
        held_expiry_d = '0;
      end

      if (cur_mode != 3'(bdmr_pkg::MODE_DEFAULT)) begin
        cand = cur_mode;
      end else if (time_known && bdmr_pkg::in_window(hour_i, cfg_i.peak_start_hour,
                                                     cfg_i.peak_end_hour)) begin
        cand = bdmr_pkg::MODE_PEAK;
      end else if (time_known && bdmr_pkg::in_window(hour_i, cfg_i.charge_start_hour,
                                                     cfg_i.charge_end_hour)) begin
        cand = bdmr_pkg::MODE_CHARGE;
      end

      mode = cand;
      if (cand == 3'(bdmr_pkg::MODE_PEAK)) begin
        if (!item_i.bms_ok || low) begin
          protect_d = 1'b1;
        end else if (protect_q && (11'(item_i.soc_tenths) >= min_release)) begin
          protect_d = 1'b0;
        end
        if (protect_d) begin
          mode = bdmr_pkg::MODE_PROTECT;
        end
      end else begin
        protect_d = 1'b0;
      end

      if (!item_i.bms_ok || (item_i.soc_tenths >= cfg_i.soc_max)) begin
        inhibit_d = 1'b1;
      end else if (inhibit_q && (max_sum <= 11'(cfg_i.soc_max))) begin
        inhibit_d = 1'b0;
      end

      res_d.mode         = mode;
      res_d.export_on    = 1'b1;
      res_d.discharge_on = 1'b0;
      res_d.charge_on    = !inhibit_d;
      res_d.curtail_lamp = 1'b0;
      if (mode == 3'(bdmr_pkg::MODE_PEAK)) begin
        res_d.discharge_on = !low;
        res_d.charge_on    = 1'b0;
      end else if (mode == 3'(bdmr_pkg::MODE_CURTAIL)) begin
        res_d.export_on    = 1'b0;
        res_d.charge_on    = 1'b0;
        res_d.curtail_lamp = 1'b1;
      end
      if (low) begin
        res_d.discharge_on = 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      held_mode_q   <= bdmr_pkg::MODE_DEFAULT;
      held_expiry_q <= '0;
      protect_q     <= 1'b0;
      inhibit_q     <= 1'b0;
      res_valid_q   <= 1'b0;
    end else if (adv_i) begin
      res_valid_q <= valid_i && !item_i.req_type;
      if (valid_i) begin
        held_mode_q   <= held_mode_d;
        held_expiry_q <= held_expiry_d;
        protect_q     <= protect_d;
        inhibit_q     <= inhibit_d;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (adv_i) begin
      res_q <= res_d;
    end
  end

  assign res_valid_o = res_valid_q;
  assign res_o       = res_q;

endmodule

// File: verif/tb_battery_dispatch_mode_relay_controller_core.sv
// ----------------------------------------------------------------------------
// tb_battery_dispatch_mode_relay_controller_core
// Self-checking bench for the dispatch mode relay controller. Request items
// are queued by a stimulus process, driven by a clocked driver and predicted
// at transfer. A clocked monitor checks each result field against the oldest
// predicted one. Register settings change only while the pipe is drained.
// ----------------------------------------------------------------------------
module tb_battery_dispatch_mode_relay_controller_core;
  timeunit 1ns;
  timeprecision 1ps;

  import bdmr_pkg::*;

  localparam int unsigned ClkHalf     = 4;
  localparam int unsigned SecsPerDay  = 86400;
  localparam int unsigned SecsPerHour = 3600;
  localparam logic        ReqPoll     = 1'b0;
  localparam logic        ReqCommand  = 1'b1;
  localparam logic [2:0]  ModeBadLo   = 3'd6;
  localparam logic [2:0]  ModeBadHi   = 3'd7;
  localparam logic [31:0] DayBase     = 32'd1699920000;  // midnight UTC
  localparam logic [31:0] EpochMax    = 32'hFFFF_FFFF;
  localparam int          DrainCycles = 8;

  typedef logic [9:0] reg_set_t [8];

  logic clk = 1'b0;
  logic rst_n;

  bdmr_req_if req_bus ();
  bdmr_res_if res_bus ();

  logic       cfg_we;
  reg_idx_e   cfg_idx;
  logic [9:0] cfg_wdata;

  battery_dispatch_mode_relay_controller_core DUT (
    .clk_i       (clk),
    .rst_ni      (rst_n),
    .req         (req_bus),
    .res         (res_bus),
    .cfg_we_i    (cfg_we),
    .cfg_idx_i   (cfg_idx),
    .cfg_wdata_i (cfg_wdata)
  );

  always #ClkHalf clk = ~clk;

  // pending requests and predicted results
  req_t item_q[$];
  res_t mode_relay_q[$];

  // shadow of the block's registers and state
  logic [9:0]  shadow_reg [8] = '{10'd0, 10'd0, 10'd0, 10'd0,
                                  10'd200, 10'd50, 10'd950, 10'd30};
  mode_e       held_mode    = MODE_DEFAULT;
  logic [31:0] held_expiry  = '0;
  logic        protect_on   = 1'b0;
  logic        inhibit_on   = 1'b0;

  int send_idle_pct = 0;
  int recv_idle_pct = 0;
  int issued_cnt    = 0;
  int accepted_cnt  = 0;
  int n_polls       = 0;
  int n_cmds        = 0;
  int n_checked     = 0;
  int n_cfg         = 0;
  int errors        = 0;
  logic req_taken   = 1'b0;

  // random generator walk state
  logic [31:0] gen_epoch   = DayBase;
  logic [31:0] last_expiry = DayBase;
  int          gen_soc     = 500;

  // --------------------------------------------------------------------------
  // Predictor
  // --------------------------------------------------------------------------
  function automatic logic hour_in_span(input logic [4:0] h, input logic [4:0] s,
                                        input logic [4:0] e);
    if (s == e) return 1'b0;
    if (s < e) return (h >= s) && (h < e);
    return (h >= s) || (h < e);
  endfunction

  function automatic void dispatch_step(input req_t r);
    logic [4:0] hr;
    mode_e      pick;
    logic       low;
    int         soc, smin, smax;
    res_t       o;
    if (r.req_type == ReqCommand) begin
      held_mode   = (r.cmd_mode > MODE_FORCED) ? MODE_DEFAULT : mode_e'(r.cmd_mode);
      held_expiry = r.cmd_expiry;
      n_cmds++;
      return;
    end
    n_polls++;
    soc  = r.soc_tenths;
    smin = shadow_reg[REG_SOC_MIN];
    smax = shadow_reg[REG_SOC_MAX];
    if (held_expiry != 0 && r.epoch_sec >= held_expiry) begin
      held_mode   = MODE_DEFAULT;
      held_expiry = '0;
    end
    hr = 5'((r.epoch_sec % SecsPerDay) / SecsPerHour);
    pick = MODE_DEFAULT;
    if (held_mode != MODE_DEFAULT)
      pick = held_mode;
    else if (r.epoch_sec != 0 &&
             hour_in_span(hr, shadow_reg[REG_PEAK_START][4:0], shadow_reg[REG_PEAK_END][4:0]))
      pick = MODE_PEAK;
    else if (r.epoch_sec != 0 &&
             hour_in_span(hr, shadow_reg[REG_CHARGE_START][4:0],
                          shadow_reg[REG_CHARGE_END][4:0]))
      pick = MODE_CHARGE;

    o.mode = pick;
    if (pick == MODE_PEAK) begin
      if (!r.bms_ok || soc < smin)
        protect_on = 1'b1;
      else if (protect_on && soc >= smin + int'(shadow_reg[REG_SOC_MIN_BAND]))
        protect_on = 1'b0;
      if (protect_on) o.mode = MODE_PROTECT;
    end else begin
      protect_on = 1'b0;
    end

    low = soc < smin;
    if (!r.bms_ok || soc >= smax)
      inhibit_on = 1'b1;
    else if (inhibit_on && soc <= smax - int'(shadow_reg[REG_SOC_MAX_BAND]))
      inhibit_on = 1'b0;

    o.export_on    = 1'b1;
    o.discharge_on = 1'b0;
    o.charge_on    = !inhibit_on;
    o.curtail_lamp = 1'b0;
    if (o.mode == MODE_PEAK) begin
      o.discharge_on = !low;
      o.charge_on    = 1'b0;
    end else if (o.mode == MODE_CURTAIL) begin
      o.export_on    = 1'b0;
      o.charge_on    = 1'b0;
      o.curtail_lamp = 1'b1;
    end
    if (low) o.discharge_on = 1'b0;
    mode_relay_q.push_back(o);
  endfunction

  // --------------------------------------------------------------------------
  // Driver and monitor
  // --------------------------------------------------------------------------
  always @(negedge clk) begin
    if (rst_n) begin
      if (!req_bus.valid || req_taken) begin
        if (item_q.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
          req_bus.payload <= item_q.pop_front();
          req_bus.valid   <= 1'b1;
        end else begin
          req_bus.valid <= 1'b0;
        end
      end
      res_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  task automatic check_field(input string name, input logic [2:0] exp_v,
                             input logic [2:0] act_v);
    if (exp_v !== act_v) begin
      $display("%0t: %s expected %0d, got %0d", $time, name, exp_v, act_v);
      errors++;
    end
  endtask

  always @(posedge clk) begin : mon
    res_t want, got;
    req_taken <= rst_n && req_bus.valid && req_bus.ready;
    if (rst_n) begin
      // results leave well after their request, so check before predicting
      if (res_bus.valid && res_bus.ready) begin
        got = res_bus.payload;
        if (mode_relay_q.size() == 0) begin
          $display("%0t: unexpected result, expected none, got %p", $time, got);
          errors++;
        end else begin
          want = mode_relay_q.pop_front();
          check_field("mode", want.mode, got.mode);
          check_field("export_on", want.export_on, got.export_on);
          check_field("discharge_on", want.discharge_on, got.discharge_on);
          check_field("charge_on", want.charge_on, got.charge_on);
          check_field("curtail_lamp", want.curtail_lamp, got.curtail_lamp);
          n_checked++;
        end
      end
      if (req_bus.valid && req_bus.ready) begin
        dispatch_step(req_bus.payload);
        accepted_cnt <= accepted_cnt + 1;
      end
    end
  end

  // --------------------------------------------------------------------------
  // Stimulus
  // --------------------------------------------------------------------------
  function automatic void queue_poll(input logic [31:0] epoch, input logic ok,
                                     input logic [9:0] soc);
    req_t r;
    r.req_type   = ReqPoll;
    r.epoch_sec  = epoch;
    r.bms_ok     = ok;
    r.soc_tenths = soc;
    r.cmd_mode   = 3'($urandom);
    r.cmd_expiry = $urandom;
    item_q.push_back(r);
    issued_cnt++;
  endfunction

  function automatic void queue_command(input logic [2:0] m, input logic [31:0] expiry);
    req_t r;
    r.req_type   = ReqCommand;
    r.epoch_sec  = $urandom;
    r.bms_ok     = 1'($urandom);
    r.soc_tenths = 10'($urandom_range(1000));
    r.cmd_mode   = m;
    r.cmd_expiry = expiry;
    item_q.push_back(r);
    issued_cnt++;
  endfunction

  function automatic logic [31:0] at_hour(input int h);
    return DayBase + h * SecsPerHour + $urandom_range(SecsPerHour - 1);
  endfunction

  function automatic void queue_random_item();
    int          pick, th;
    logic [31:0] ep;
    pick = $urandom_range(99);
    if (pick < 15) begin
      pick = $urandom_range(99);
      if (pick < 35)      last_expiry = '0;
      else if (pick < 85) last_expiry = gen_epoch + $urandom_range(4 * SecsPerHour);
      else                last_expiry = $urandom;
      queue_command(3'($urandom_range(7)), last_expiry);
      return;
    end
    gen_epoch = gen_epoch + $urandom_range(5400, 1);
    pick = $urandom_range(99);
    if (pick < 80)      ep = gen_epoch;
    else if (pick < 87) ep = '0;
    else if (pick < 95) ep = $urandom;
    else                ep = last_expiry + $urandom_range(2) - 1;  // straddle the lapse

    // state of charge walks, with a pull toward the latch thresholds
    pick = $urandom_range(99);
    if (pick < 30) begin
      gen_soc = gen_soc + $urandom_range(40) - 20;
    end else if (pick < 70) begin
      case ($urandom_range(3))
        0:       th = shadow_reg[REG_SOC_MIN];
        1:       th = shadow_reg[REG_SOC_MIN] + shadow_reg[REG_SOC_MIN_BAND];
        2:       th = shadow_reg[REG_SOC_MAX];
        default: th = int'(shadow_reg[REG_SOC_MAX]) - int'(shadow_reg[REG_SOC_MAX_BAND]);
      endcase
      gen_soc = th + $urandom_range(4) - 2;
    end else if (pick < 80) begin
      gen_soc = $urandom_range(1) ? 1000 : 0;
    end else begin
      gen_soc = $urandom_range(1000);
    end
    if (gen_soc < 0) gen_soc = 0;
    if (gen_soc > 1000) gen_soc = 1000;
    queue_poll(ep, $urandom_range(99) < 90, 10'(gen_soc));
  endfunction

  function automatic reg_set_t random_config();
    reg_set_t v;
    for (int i = 0; i < 8; i++) begin
      if (reg_idx_e'(i) <= REG_CHARGE_END) begin
        case ($urandom_range(9))
          0:       v[i] = 10'd0;
          1:       v[i] = 10'd23;
          2, 3:    v[i] = 10'($urandom);  // upper bits dropped by the register
          default: v[i] = 10'($urandom_range(23));
        endcase
      end else begin
        case ($urandom_range(9))
          0:       v[i] = 10'd0;
          1:       v[i] = 10'd1000;
          default: v[i] = 10'($urandom_range(reg_idx_e'(i) == REG_SOC_MIN_BAND ||
                                             reg_idx_e'(i) == REG_SOC_MAX_BAND ? 300 : 1000));
        endcase
      end
    end
    return v;
  endfunction

  task automatic program_config(input reg_set_t v);
    for (int i = 0; i < 8; i++) begin
      @(negedge clk);
      cfg_we    <= 1'b1;
      cfg_idx   <= reg_idx_e'(i);
      cfg_wdata <= v[i];
      shadow_reg[i] = (reg_idx_e'(i) <= REG_CHARGE_END) ? (v[i] & 10'h01F) : v[i];
    end
    @(negedge clk);
    cfg_we <= 1'b0;
    n_cfg++;
  endtask

  // commands leave no result, so hold off a full pipe depth after the last one
  task automatic wait_drained();
    while (accepted_cnt != issued_cnt || mode_relay_q.size() != 0) @(negedge clk);
    repeat (DrainCycles) @(negedge clk);
  endtask

  task automatic run_phase(input bit write_cfg, input reg_set_t v, input int snd,
                           input int rcv, input int n);
    if (write_cfg) program_config(v);
    @(posedge clk);
    send_idle_pct = snd;
    recv_idle_pct = rcv;
    repeat (n) queue_random_item();
    wait_drained();
  endtask

  task automatic directed_items();
    queue_poll('0, 1'b1, 10'd500);                   // unknown time
    queue_poll(at_hour(18), 1'b1, 10'd500);          // peak window
    queue_poll(at_hour(18), 1'b1, 10'd150);          // protect sets
    queue_poll(at_hour(18), 1'b1, 10'd230);          // inside recovery band
    queue_poll(at_hour(18), 1'b1, 10'd250);          // protect releases
    queue_poll(at_hour(18), 1'b0, 10'd600);          // bad BMS
    queue_poll(at_hour(23), 1'b1, 10'd600);          // wrapped charge window
    queue_poll(at_hour(3), 1'b1, 10'd950);           // inhibit at ceiling
    queue_poll(at_hour(3), 1'b1, 10'd930);
    queue_poll(at_hour(3), 1'b1, 10'd920);           // inhibit releases
    queue_poll(DayBase + 6 * SecsPerHour, 1'b1, 10'd1000);  // end hour exclusive
    queue_poll(at_hour(12), 1'b1, 10'd0);
    queue_command(MODE_CURTAIL, DayBase + 13 * SecsPerHour);
    queue_poll(DayBase + 13 * SecsPerHour - 1, 1'b1, 10'd500);
    queue_poll(DayBase + 13 * SecsPerHour, 1'b1, 10'd500);  // lapses exactly here
    queue_command(ModeBadHi, '0);
    queue_poll(at_hour(19), 1'b1, 10'd1000);
    queue_command(ModeBadLo, '0);
    queue_command(MODE_PEAK, '0);
    queue_poll(at_hour(10), 1'b1, 10'd100);          // commanded peak, protected
    queue_poll('0, 1'b1, 10'd700);                   // no lapse with unknown time
    queue_command(MODE_FORCED, EpochMax);
    queue_poll(at_hour(18), 1'b1, 10'd199);
    queue_poll(EpochMax, 1'b1, 10'd200);
    queue_command(MODE_PROTECT, '0);
    queue_poll(at_hour(20), 1'b1, 10'd999);
    queue_command(MODE_CHARGE, '0);
    queue_poll(at_hour(8), 1'b1, 10'd500);
  endtask

  initial begin
    rst_n           = 1'b0;
    req_bus.valid   = 1'b0;
    req_bus.payload = '0;
    res_bus.ready   = 1'b0;
    cfg_we          = 1'b0;
    cfg_idx         = REG_PEAK_START;
    cfg_wdata       = '0;
    repeat (10) @(negedge clk);
    rst_n = 1'b1;

    // reset register values first
    run_phase(1'b0, random_config(), 36, 83, 60);

    program_config('{10'd17, 10'd21, 10'd22, 10'd6, 10'd200, 10'd50, 10'd950, 10'd30});
    @(posedge clk);
    directed_items();
    repeat (80) queue_random_item();
    wait_drained();

    run_phase(1'b1, random_config(), 36, 83, 90);
    run_phase(1'b1, '{10'd0, 10'd23, 10'd23, 10'd0, 10'd1000, 10'd1000, 10'd0, 10'd1000},
              83, 36, 90);
    // peak hours 31 to 24 wrap and cover the whole day
    run_phase(1'b1, '{10'h3FF, 10'd24, 10'd0, 10'd23, 10'd0, 10'd0, 10'd1000, 10'd0},
              83, 36, 90);
    run_phase(1'b1, random_config(), 83, 36, 90);
    run_phase(1'b1, random_config(), 0, 0, 100);
    run_phase(1'b1, random_config(), 0, 0, 100);
    // both windows off, release band wider than the ceiling
    run_phase(1'b1, '{10'd5, 10'd5, 10'd9, 10'd9, 10'd300, 10'd0, 10'd500, 10'd600},
              0, 0, 100);

    $display("Covered %0d polls and %0d commands over %0d register settings;",
             n_polls, n_cmds, n_cfg);
    $display("%0d results checked field by field, %0d errors.", n_checked, errors);
    if (errors == 0) begin
      $display("battery_dispatch_mode_relay_controller_core: match");
    end else begin
      $display("battery_dispatch_mode_relay_controller_core: mismatch");
    end
    $finish;
  end

  initial begin
    #2_000_000;
    $display("Timeout: %0d of %0d items transferred", accepted_cnt, issued_cnt);
    $display("battery_dispatch_mode_relay_controller_core: mismatch");
    $finish;
  end

endmodule
